[rtl/pdc_pkg.sv]
// Package for the framed packet receiver: event codes, register indexes,
// CRC-16/CCITT-FALSE constants and the byte-wide CRC update function.
// No dependencies.
package pdc_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_WORD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_END_BYTE    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH  = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // Reset value of the length limit
  localparam logic [15:0] MAX_LENGTH_RST = 16'd256;

  // Result event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_ACCEPT  = 3'd2;
  localparam logic [2:0] EV_CRCBAD  = 3'd3;
  localparam logic [2:0] EV_TOOLONG = 3'd4;
  localparam logic [2:0] EV_BADEND  = 3'd5;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // One byte through the CRC, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/packet_deframer_crc16_check.sv]
// Framed packet receiver top level: frame state machine, running CRC and
// result register. Depends on pdc_pkg.
//
// Takes one received byte per beat and emits exactly one result beat per byte. The
// frame parser, the CRC-16/CCITT-FALSE update and the verdict all sit between the
// state registers and a single result register, so a byte is accepted every cycle
// and its result is registered; the only thing that stalls input is a
// result still waiting in that register while out_ready_i is low. Frames are:
// header low, header high, command, length low, length high, payload, CRC low,
// CRC high, end byte. The CRC covers command, length bytes and payload. Payload
// bytes are passed on as they arrive; a final event gives accept, CRC mismatch,
// oversize length or bad end byte. Configuration writes
// must only be made while no result is pending.
module packet_deframer_crc16_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [pdc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pdc_pkg::CfgDataW-1:0]  cfg_data_i,
  // Byte input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  // Result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    event_res_o,
  output logic [7:0]                    payload_byte_o,
  output logic [15:0]                   payload_index_o,
  output logic [7:0]                    frame_cmd_o,
  output logic [15:0]                   frame_length_o
);
  import pdc_pkg::*;

  // Frame phases
  localparam logic [2:0] PH_HUNT1 = 3'd0;
  localparam logic [2:0] PH_HUNT2 = 3'd1;
  localparam logic [2:0] PH_CMD   = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CRC   = 3'd5;
  localparam logic [2:0] PH_END   = 3'd6;

  // Configuration registers
  logic [15:0] header_word_q;
  logic [7:0]  end_byte_q;
  logic [15:0] max_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_word_q <= '0;
      end_byte_q    <= '0;
      max_length_q  <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HEADER_WORD: header_word_q <= cfg_data_i[15:0];
        CFG_END_BYTE:    end_byte_q    <= cfg_data_i[7:0];
        CFG_MAX_LENGTH:  max_length_q  <= cfg_data_i[15:0];
        default:         ;
      endcase
    end
  end

  // Frame state
  logic [2:0]  phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [15:0] length_q, length_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_rx_q, crc_rx_d;

  // Result register
  logic        out_valid_q;
  logic [2:0]  event_q, event_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic [15:0] pidx_q, pidx_d;
  logic [15:0] flen_q;
  logic [7:0]  fcmd_q;

  logic        in_fire;
  logic [15:0] crc_next;
  logic [15:0] len_full;
  logic [15:0] crc_full;
  logic [15:0] count_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign crc_next  = crc_feed(crc_q, rx_byte_i);
  assign len_full  = {rx_byte_i, length_q[7:0]};
  assign crc_full  = {rx_byte_i, crc_rx_q[7:0]};
  assign count_inc = count_q + 16'd1;

  // Next-state and result logic for one byte
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    length_d = length_q;
    cmd_d    = cmd_q;
    crc_d    = crc_q;
    crc_rx_d = crc_rx_q;
    event_d  = EV_NONE;
    pbyte_d  = '0;
    pidx_d   = '0;
    unique case (phase_q)
      PH_HUNT2: begin
        if (rx_byte_i == header_word_q[15:8]) begin
          cmd_d    = '0;
          length_d = '0;
          phase_d  = PH_CMD;
        end else begin
          phase_d = PH_HUNT1;
        end
      end
      PH_CMD: begin
        cmd_d   = rx_byte_i;
        crc_d   = crc_next;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        crc_d = crc_next;
        if (count_q == 16'd0) begin
          length_d = {length_q[15:8], rx_byte_i};
          count_d  = 16'd1;
        end else begin
          length_d = len_full;
          count_d  = '0;
          if (len_full > max_length_q) begin
            event_d = EV_TOOLONG;
            phase_d = PH_HUNT1;
          end else if (len_full == 16'd0) begin
            phase_d = PH_CRC;
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        crc_d   = crc_next;
        event_d = EV_PAYLOAD;
        pbyte_d = rx_byte_i;
        pidx_d  = count_q;
        if (count_inc == length_q) begin
          count_d = '0;
          phase_d = PH_CRC;
        end else begin
          count_d = count_inc;
        end
      end
      PH_CRC: begin
        if (count_q == 16'd0) begin
          crc_rx_d = {crc_rx_q[15:8], rx_byte_i};
          count_d  = 16'd1;
        end else begin
          crc_rx_d = crc_full;
          count_d  = '0;
          if (crc_full == crc_q) begin
            phase_d = PH_END;
          end else begin
            event_d = EV_CRCBAD;
            phase_d = PH_HUNT1;
          end
        end
      end
      PH_END: begin
        event_d = (rx_byte_i == end_byte_q) ? EV_ACCEPT : EV_BADEND;
        phase_d = PH_HUNT1;
      end
      default: begin
        // hunting for the first header byte (unused code 7 lands here too)
        if (rx_byte_i == header_word_q[7:0]) begin
          count_d  = '0;
          crc_rx_d = '0;
          crc_d    = CRC_INIT;
          phase_d  = PH_HUNT2;
        end else begin
          phase_d = PH_HUNT1;
        end
      end
    endcase
  end

  // State registers, advanced once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT1;
      count_q  <= '0;
      length_q <= '0;
      cmd_q    <= '0;
      crc_q    <= CRC_INIT;
      crc_rx_q <= '0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      length_q <= length_d;
      cmd_q    <= cmd_d;
      crc_q    <= crc_d;
      crc_rx_q <= crc_rx_d;
    end
  end

  // Result beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      event_q <= event_d;
      pbyte_q <= pbyte_d;
      pidx_q  <= pidx_d;
      fcmd_q  <= cmd_d;
      flen_q  <= length_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = event_q;
  assign payload_byte_o  = pbyte_q;
  assign payload_index_o = pidx_q;
  assign frame_cmd_o     = fcmd_q;
  assign frame_length_o  = flen_q;

  // Checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_data_gives_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PH_DATA) |=> (out_valid_q && event_q == EV_PAYLOAD))
    else $error("payload byte did not produce a payload event");

  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && event_q == EV_PAYLOAD) |-> (pidx_q < flen_q))
    else $error("payload index beyond frame length");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && event_q != EV_PAYLOAD) |-> (pbyte_q == 8'd0 && pidx_q == 16'd0))
    else $error("payload fields set on a non-payload event");

  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (event_q <= EV_BADEND))
    else $error("event code out of range");

endmodule

[verif/pdc_tb_pkg.sv]
// Scoreboard for the framed packet receiver testbench: frame tracker, CRC helper
// and the queue of expected result beats. Depends on pdc_pkg.
`timescale 1ns / 100ps
package pdc_tb_pkg;
  import pdc_pkg::*;

  // Receiver phases as tracked on the testbench side
  typedef enum logic [2:0] {
    RX_HUNT_LO,
    RX_HUNT_HI,
    RX_CMD,
    RX_LEN,
    RX_DATA,
    RX_CRC,
    RX_END
  } rx_phase_e;

  // One result beat
  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  pbyte;
    logic [15:0] pidx;
    logic [7:0]  cmd;
    logic [15:0] len;
  } rx_result_t;

  // CCITT-FALSE update, one data bit at a time, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    int i;
    c = crc;
    for (i = 7; i >= 0; i--) begin
      if (c[15] ^ data[i]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  class deframer_scoreboard;
    // register copies
    logic [15:0] hdr_word;
    logic [7:0]  end_code;
    logic [15:0] len_limit;
    // frame tracking state
    rx_phase_e   ph;
    logic [15:0] cnt;
    logic [15:0] len;
    logic [7:0]  cmd;
    logic [15:0] crc_calc;
    logic [15:0] crc_got;
    rx_result_t  result_q[$];
    int unsigned mismatches;

    function new();
      hdr_word   = '0;
      end_code   = '0;
      len_limit  = MAX_LENGTH_RST;
      ph         = RX_HUNT_LO;
      cnt        = '0;
      len        = '0;
      cmd        = '0;
      crc_calc   = CRC_INIT;
      crc_got    = '0;
      mismatches = 0;
    endfunction

    function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
      case (idx)
        CFG_HEADER_WORD: hdr_word = data[15:0];
        CFG_END_BYTE:    end_code = data[7:0];
        CFG_MAX_LENGTH:  len_limit = data[15:0];
        default: ;  // unused index, nothing changes
      endcase
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    // Advance the frame tracker by one accepted byte and queue its result beat
    function void take_byte(input logic [7:0] b);
      rx_result_t r;
      r = '0;
      case (ph)
        RX_HUNT_HI: begin
          if (b == hdr_word[15:8]) begin
            cmd = '0;
            len = '0;
            ph  = RX_CMD;
          end else begin
            ph = RX_HUNT_LO;  // mismatching byte is not retried as a first byte
          end
        end
        RX_CMD: begin
          cmd      = b;
          crc_calc = crc16_step(crc_calc, b);
          ph       = RX_LEN;
        end
        RX_LEN: begin
          crc_calc = crc16_step(crc_calc, b);
          if (cnt == 16'd0) begin
            len[7:0] = b;
            cnt      = 16'd1;
          end else begin
            len[15:8] = b;
            cnt       = '0;
            if (len > len_limit) begin
              r.ev = EV_TOOLONG;
              ph   = RX_HUNT_LO;
            end else if (len == 16'd0) begin
              ph = RX_CRC;
            end else begin
              ph = RX_DATA;
            end
          end
        end
        RX_DATA: begin
          crc_calc = crc16_step(crc_calc, b);
          r.ev     = EV_PAYLOAD;
          r.pbyte  = b;
          r.pidx   = cnt;
          cnt      = cnt + 16'd1;
          if (cnt == len) begin
            cnt = '0;
            ph  = RX_CRC;
          end
        end
        RX_CRC: begin
          if (cnt == 16'd0) begin
            crc_got[7:0] = b;
            cnt          = 16'd1;
          end else begin
            crc_got[15:8] = b;
            cnt           = '0;
            if (crc_got == crc_calc) begin
              ph = RX_END;
            end else begin
              r.ev = EV_CRCBAD;
              ph   = RX_HUNT_LO;
            end
          end
        end
        RX_END: begin
          r.ev = (b == end_code) ? EV_ACCEPT : EV_BADEND;
          ph   = RX_HUNT_LO;
        end
        default: begin
          if (b == hdr_word[7:0]) begin
            cnt      = '0;
            crc_got  = '0;
            crc_calc = CRC_INIT;
            ph       = RX_HUNT_HI;
          end else begin
            ph = RX_HUNT_LO;
          end
        end
      endcase
      r.cmd = cmd;
      r.len = len;
      result_q.push_back(r);
    endfunction

    // Compare one result beat against the oldest expected beat
    function void match_result(input rx_result_t got);
      rx_result_t want;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result beat ev=%0d byte=%02h idx=%0d cmd=%02h len=%0d",
                   $time, got.ev, got.pbyte, got.pidx, got.cmd, got.len);
        end
        return;
      end
      want = result_q.pop_front();
      if (got.ev !== want.ev || got.pbyte !== want.pbyte || got.pidx !== want.pidx ||
          got.cmd !== want.cmd || got.len !== want.len) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp ev=%0d byte=%02h idx=%0d cmd=%02h len=%0d", $time,
                   want.ev, want.pbyte, want.pidx, want.cmd, want.len);
          $display("%0t:          got ev=%0d byte=%02h idx=%0d cmd=%02h len=%0d", $time,
                   got.ev, got.pbyte, got.pidx, got.cmd, got.len);
        end
      end
    endfunction
  endclass

endpackage

[verif/tb_top.sv]
// Top of the framed packet receiver testbench: clock, reset, byte driver, result sink
// and stimulus sequence. Depends on pdc_pkg, pdc_tb_pkg and the receiver RTL.
`timescale 1ns / 100ps
module tb_top;
  import pdc_pkg::*;
  import pdc_tb_pkg::*;

  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned RandomBytes = 2000;
  localparam int unsigned NumPhases   = 8;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_END, FR_BAD_HDR, FR_OVERSIZE} frame_kind_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          rx_byte_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [2:0]          event_res_o;
  logic [7:0]          payload_byte_o;
  logic [15:0]         payload_index_o;
  logic [7:0]          frame_cmd_o;
  logic [15:0]         frame_length_o;

  deframer_scoreboard sb = new();
  bit          calm        = 1'b0;  // no idling on either side while set
  int unsigned frame_bytes = 0;
  int unsigned cycle_cnt   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  packet_deframer_crc16_check dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .payload_byte_o (payload_byte_o),
    .payload_index_o(payload_index_o),
    .frame_cmd_o    (frame_cmd_o),
    .frame_length_o (frame_length_o)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // One input beat, with a random idle gap ahead of it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    sb.take_byte(b);
  endtask

  // Build a frame for the current registers, spoil it as asked, optionally cut it short
  task automatic send_frame(input frame_kind_e kind, input logic [7:0] cmd,
                            input logic [15:0] len, input int unsigned cut);
    logic [7:0]  bytes_q[$];
    logic [7:0]  head[3];
    logic [15:0] crc;
    logic [7:0]  b;
    int unsigned i;
    bytes_q.push_back(sb.hdr_word[7:0]);
    if (kind == FR_BAD_HDR) begin
      bytes_q.push_back(sb.hdr_word[15:8] ^ 8'($urandom_range(1, 255)));
    end else begin
      bytes_q.push_back(sb.hdr_word[15:8]);
      crc  = CRC_INIT;
      head = '{cmd, len[7:0], len[15:8]};
      foreach (head[k]) begin
        bytes_q.push_back(head[k]);
        crc = crc16_step(crc, head[k]);
      end
      if (kind != FR_OVERSIZE) begin
        for (i = 0; i < len; i++) begin
          b = 8'($urandom);
          bytes_q.push_back(b);
          crc = crc16_step(crc, b);
        end
        if (kind == FR_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
        bytes_q.push_back(crc[7:0]);
        bytes_q.push_back(crc[15:8]);
        if (kind == FR_BAD_END) begin
          bytes_q.push_back(sb.end_code ^ 8'($urandom_range(1, 255)));
        end else begin
          bytes_q.push_back(sb.end_code);
        end
      end
    end
    while (cut != 0 && bytes_q.size() > cut) void'(bytes_q.pop_back());
    foreach (bytes_q[j]) send_byte(bytes_q[j]);
    frame_bytes += bytes_q.size();
  endtask

  // Stop sending and wait for every outstanding result beat
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] hdr, input logic [15:0] endv,
                           input logic [15:0] lim);
    drain();
    write_reg(CFG_HEADER_WORD, hdr);
    write_reg(CFG_END_BYTE, endv);
    write_reg(CFG_MAX_LENGTH, lim);
  endtask

  // Result sink: check accepted beats, then choose next ready value
  initial begin : result_sink
    int unsigned stall;
    rx_result_t  got;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.ev    = event_res_o;
        got.pbyte = payload_byte_o;
        got.pidx  = payload_index_o;
        got.cmd   = frame_cmd_o;
        got.len   = frame_length_o;
        sb.match_result(got);
      end
      if (stall != 0 && !calm) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned      phase_i;
    int unsigned      r;
    int unsigned      cap;
    int unsigned      cut;
    logic [15:0]      hdr;
    logic [15:0]      lim;
    logic [15:0]      flen;
    logic [7:0]       hb;
    frame_kind_e      kind;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: header 00 then FF, end FF, limit one byte
    configure(16'hFF00, 16'h00FF, 16'd1);
    write_reg(CFG_UNUSED, 16'hFFFF);          // unused index must be ignored
    send_frame(FR_GOOD, 8'hFF, 16'd0, 0);     // zero length goes straight to CRC
    send_byte(8'h00);                         // first header byte
    send_byte(8'h00);                         // wrong second byte, not retried
    send_byte(8'hFF);
    send_frame(FR_BAD_END, 8'h00, 16'd1, 0);  // length equal to the limit
    send_frame(FR_OVERSIZE, 8'h5A, 16'hFFFF, 0);
    send_frame(FR_BAD_CRC, 8'hA5, 16'd0, 0);

    // Random phases, each with its own register setting
    frame_bytes = 0;
    for (phase_i = 0; phase_i < NumPhases; phase_i++) begin
      hb  = 8'($urandom);
      hdr = ($urandom_range(0, 3) == 0) ? {hb, hb} : 16'($urandom);
      case ($urandom_range(0, 5))
        0:       lim = 16'd0;
        1:       lim = 16'd1;
        2:       lim = MAX_LENGTH_RST;
        3:       lim = 16'hFFFF;
        4:       lim = 16'($urandom_range(2, 40));
        default: lim = 16'($urandom);
      endcase
      if (phase_i == 0) begin
        configure(16'h0000, 16'h0000, 16'd0);
      end else if (phase_i == 1) begin
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
      end else begin
        configure(hdr, 16'($urandom), lim);
      end
      while (frame_bytes < (phase_i + 1) * RandomBytes / NumPhases) begin
        if ($urandom_range(0, 19) == 0) calm = !calm;
        if ($urandom_range(0, 99) < 15) begin
          // line noise between frames
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 55)      kind = FR_GOOD;
          else if (r < 65) kind = FR_BAD_CRC;
          else if (r < 75) kind = FR_BAD_END;
          else if (r < 83) kind = FR_BAD_HDR;
          else             kind = FR_OVERSIZE;
          if (kind == FR_OVERSIZE && sb.len_limit == 16'hFFFF) kind = FR_GOOD;
          if (kind == FR_OVERSIZE) begin
            flen = 16'($urandom_range(sb.len_limit + 1, 32'hFFFF));
          end else begin
            cap = (sb.len_limit < 64) ? sb.len_limit : 64;
            if ($urandom_range(0, 3) != 0 && cap > 8) cap = 8;
            flen = 16'($urandom_range(0, cap));
          end
          cut = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 12) : 0;
          send_frame(kind, 8'($urandom), flen, cut);
        end
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    // One long frame under the widest limit, sent at full rate
    configure(16'($urandom), 16'($urandom), 16'hFFFF);
    calm = 1'b1;
    send_frame(FR_GOOD, 8'($urandom), 16'd128, 0);
    calm = 1'b0;

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
